/* rtl/core/anc_pkg.sv */
package anc_pkg;

  localparam int unsigned ENTRIES_DEF      = 32;
  localparam int unsigned PORTS_DEF        = 8;
  localparam int unsigned REMOVE_LIMIT_DEF = 64;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned PORT_W  = 3;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RETRY_W = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned RCNT_W  = 6;
  localparam int unsigned TMO_W   = 17;
  localparam int unsigned PCNT_W  = 4;
  localparam int unsigned CIDX_W  = 1;

  localparam int unsigned RETRY_STEPS    = 5;
  localparam int unsigned RETRY_STEP_SEC = 60;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET    = TMO_W'(20 * 60);
  localparam logic [PCNT_W-1:0] PORT_COUNT_RESET = PCNT_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LEARN   = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_REFRESH = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATED = 3'd0,
    KIND_CREATED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_HIT     = 3'd3,
    KIND_MISS    = 3'd4,
    KIND_BADPORT = 3'd5,
    KIND_PROBE   = 3'd6,
    KIND_DONE    = 3'd7
  } kind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TIMEOUT    = 1'b0,
    CFG_PORT_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_COMPACT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FROM_PREV,
    OP_FROM_NEXT,
    OP_WRITE_NEW,
    OP_BUMP,
    OP_KILL
  } cell_op_e;

  typedef struct packed {
    logic               valid;
    logic [PORT_W-1:0]  port;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [TIME_W-1:0]  expiry;
    logic [RETRY_W-1:0] retry;
  } entry_t;

  typedef struct packed {
    logic sfx;
    logic hole;
  } chain_t;

endpackage

/* rtl/core/anc_cell.sv */
module anc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  anc_pkg::cell_op_e           op_i,
  input  anc_pkg::entry_t             prev_i,
  input  anc_pkg::entry_t             next_i,
  input  anc_pkg::entry_t             new_i,
  input  logic [anc_pkg::PORT_W-1:0]  key_port_i,
  input  logic [anc_pkg::IP_W-1:0]    key_ip_i,
  input  anc_pkg::chain_t             chain_i,
  output anc_pkg::chain_t             chain_o,
  output anc_pkg::entry_t             entry_o,
  output logic                        match_o
);
  import anc_pkg::*;

  logic   valid_q, valid_d;
  entry_t data_q, data_d;
  entry_t cur;

  always_comb begin
    cur       = data_q;
    cur.valid = valid_q;
  end

  always_comb begin
    data_d = cur;
    case (op_i)
      OP_FROM_PREV: data_d = prev_i;
      OP_FROM_NEXT: data_d = next_i;
      OP_WRITE_NEW: data_d = new_i;
      OP_BUMP:      data_d.retry = cur.retry + RETRY_W'(1);
      OP_KILL:      data_d.valid = 1'b0;
      default:      data_d = cur;
    endcase
    valid_d = data_d.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign match_o      = valid_q && (data_q.port == key_port_i) && (data_q.ip == key_ip_i);
  assign chain_o.sfx  = chain_i.sfx | match_o;
  assign chain_o.hole = chain_i.hole | ~valid_q;
  assign entry_o      = cur;

endmodule

/* rtl/core/arp_neighbor_cache_with_aging.sv */
// ARP neighbor cache: ENTRIES cells in a chain, cell 0 newest. Each cell
// compares its entry with the request key in parallel; moves to the head,
// inserts and compaction shift entries one cell along the chain per cycle.
// One request at a time. Learn and lookup results wait through any output
// stall. A refresh tick walks slots from the oldest, then compacts out the
// removed slots and reports the removed count; probe requests stream out
// during the walk. Config writes are always ready.
module arp_neighbor_cache_with_aging #(
  parameter int unsigned ENTRIES      = anc_pkg::ENTRIES_DEF,
  parameter int unsigned PORTS        = anc_pkg::PORTS_DEF,
  parameter int unsigned REMOVE_LIMIT = anc_pkg::REMOVE_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [anc_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [anc_pkg::TMO_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [anc_pkg::REQ_W-1:0]   req_type_i,
  input  logic [anc_pkg::PORT_W-1:0]  port_i,
  input  logic [anc_pkg::IP_W-1:0]    ip_address_i,
  input  logic [anc_pkg::MAC_W-1:0]   hw_addr_i,
  input  logic [anc_pkg::TIME_W-1:0]  now_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [anc_pkg::KIND_W-1:0]  kind_o,
  output logic [anc_pkg::PORT_W-1:0]  out_port_o,
  output logic [anc_pkg::IP_W-1:0]    out_ip_o,
  output logic [anc_pkg::MAC_W-1:0]   found_hw_addr_o,
  output logic [anc_pkg::RCNT_W-1:0]  removed_count_o,
  output logic                        last_o
);
  import anc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = $clog2(REMOVE_LIMIT + 1);

  logic [TMO_W-1:0]  tmo_q;
  logic [PCNT_W-1:0] pcnt_q;

  state_e state_q, state_d;

  req_e              req_q;
  logic [PORT_W-1:0] port_q;
  logic [IP_W-1:0]   ip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;
  logic [OW-1:0]     occ_q;
  logic [IW-1:0]     idx_q;
  logic [RW-1:0]     rem_q, cmp_q;

  logic              ov_q;
  kind_e             okind_q;
  logic [PORT_W-1:0] oport_q;
  logic [IP_W-1:0]   oip_q;
  logic [MAC_W-1:0]  omac_q;
  logic [RCNT_W-1:0] orem_q;
  logic              olast_q;

  entry_t   ent [ENTRIES];
  cell_op_e ops [ENTRIES];
  chain_t   chn [ENTRIES+1];
  chain_t   sfx_chn [ENTRIES+1];
  logic [ENTRIES-1:0] match;
  entry_t   new_ent;
  entry_t   empty_ent;

  logic              out_free, hit, full, bad_port;
  logic [MAC_W-1:0]  hit_mac;
  entry_t            cur;
  logic              expired, not_due;
  logic [TIME_W-1:0] back;
  logic [RW-1:0]     rem_inc, rem_fin;
  logic              walk_stop;

  logic              emit;
  kind_e             e_kind;
  logic [PORT_W-1:0] e_port;
  logic [IP_W-1:0]   e_ip;
  logic [MAC_W-1:0]  e_mac;
  logic [RCNT_W-1:0] e_rem;
  logic              e_last;
  logic              learn_go, kill_go, bump_go, compact_go, occ_inc, occ_sub;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q  <= TIMEOUT_RESET;
      pcnt_q <= PORT_COUNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:    tmo_q  <= cfg_data_i;
        CFG_PORT_COUNT: pcnt_q <= cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign empty_ent = '0;

  always_comb begin
    new_ent        = '0;
    new_ent.valid  = 1'b1;
    new_ent.port   = port_q;
    new_ent.ip     = ip_q;
    new_ent.mac    = mac_q;
    new_ent.expiry = now_q + TIME_W'(tmo_q);
    new_ent.retry  = '0;
  end

  assign chn[0].hole           = 1'b0;
  assign chn[0].sfx            = 1'b0;
  assign sfx_chn[ENTRIES].sfx  = 1'b0;
  assign sfx_chn[ENTRIES].hole = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    chain_t ci, co;
    assign ci.hole         = chn[i].hole;
    assign ci.sfx          = sfx_chn[i+1].sfx;
    assign chn[i+1].hole   = co.hole;
    assign chn[i+1].sfx    = 1'b0;
    assign sfx_chn[i].sfx  = co.sfx;
    assign sfx_chn[i].hole = 1'b0;

    always_comb begin
      ops[i] = OP_HOLD;
      if (learn_go) begin
        if (i == 0) begin
          ops[i] = OP_WRITE_NEW;
        end else if (!hit || co.sfx) begin
          ops[i] = OP_FROM_PREV;
        end
      end else if (kill_go && (idx_q == IW'(i))) begin
        ops[i] = OP_KILL;
      end else if (bump_go && (idx_q == IW'(i))) begin
        ops[i] = OP_BUMP;
      end else if (compact_go && co.hole) begin
        ops[i] = OP_FROM_NEXT;
      end
    end

    anc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (ops[i]),
      .prev_i     ((i == 0) ? empty_ent : ent[(i == 0) ? 0 : i-1]),
      .next_i     ((i == ENTRIES-1) ? empty_ent : ent[(i == ENTRIES-1) ? i : i+1]),
      .new_i      (new_ent),
      .key_port_i (port_q),
      .key_ip_i   (ip_q),
      .chain_i    (ci),
      .chain_o    (co),
      .entry_o    (ent[i]),
      .match_o    (match[i])
    );
  end

  assign hit = sfx_chn[0].sfx;

  always_comb begin
    hit_mac = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_mac = hit_mac | (match[i] ? ent[i].mac : '0);
    end
  end

  assign full     = (occ_q == OW'(ENTRIES));
  assign bad_port = ({1'b0, port_q} >= pcnt_q) || (32'(port_q) >= 32'(PORTS));
  assign out_free = !ov_q || !out_stall_i;

  assign cur     = ent[idx_q];
  assign expired = !(cur.expiry > now_q);
  assign back    = (TIME_W'(RETRY_STEPS) - TIME_W'(cur.retry)) * TIME_W'(RETRY_STEP_SEC);
  assign not_due = (cur.expiry - back) > now_q;
  assign rem_inc = rem_q + RW'(1);
  assign rem_fin = expired ? rem_inc : rem_q;
  assign walk_stop = expired ? ((rem_inc == RW'(REMOVE_LIMIT)) || (idx_q == '0))
                             : (not_due || (idx_q == '0));

  always_comb begin
    emit       = 1'b0;
    e_kind     = KIND_UPDATED;
    e_port     = '0;
    e_ip       = '0;
    e_mac      = '0;
    e_rem      = '0;
    e_last     = 1'b1;
    learn_go   = 1'b0;
    kill_go    = 1'b0;
    bump_go    = 1'b0;
    compact_go = 1'b0;
    occ_inc    = 1'b0;
    occ_sub    = 1'b0;
    case (state_q)
      ST_EXEC: begin
        if (out_free) begin
          case (req_q)
            REQ_LEARN: begin
              emit = 1'b1;
              if (hit) begin
                e_kind   = KIND_UPDATED;
                learn_go = 1'b1;
              end else if (full) begin
                e_kind = KIND_FULL;
              end else begin
                e_kind   = KIND_CREATED;
                learn_go = 1'b1;
                occ_inc  = 1'b1;
              end
            end
            REQ_LOOKUP: begin
              emit = 1'b1;
              if (bad_port) begin
                e_kind = KIND_BADPORT;
              end else if (hit) begin
                e_kind = KIND_HIT;
                e_mac  = hit_mac;
              end else begin
                e_kind = KIND_MISS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (expired) begin
            kill_go = 1'b1;
          end else if (!not_due) begin
            bump_go = 1'b1;
            emit    = 1'b1;
            e_kind  = KIND_PROBE;
            e_port  = cur.port;
            e_ip    = cur.ip;
            e_last  = 1'b0;
          end
        end
      end
      ST_COMPACT: compact_go = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_DONE;
          e_rem   = RCNT_W'(rem_q);
          occ_sub = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_e'(req_type_i) != REQ_NONE)) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q == REQ_REFRESH) begin
          state_d = (occ_q == '0) ? ST_DONE : ST_WALK;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (out_free && walk_stop) begin
          state_d = (rem_fin != '0) ? ST_COMPACT : ST_DONE;
        end
      end
      ST_COMPACT: begin
        if (cmp_q == RW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      rem_q   <= '0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      if (occ_inc) begin
        occ_q <= occ_q + OW'(1);
      end else if (occ_sub) begin
        occ_q <= occ_q - OW'(rem_q);
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if ((state_q == ST_EXEC) && (req_q == REQ_REFRESH)) begin
        idx_q <= IW'(occ_q - OW'(1));
        rem_q <= '0;
      end else if ((state_q == ST_WALK) && out_free) begin
        rem_q <= rem_fin;
        idx_q <= idx_q - IW'(1);
        if (walk_stop) begin
          cmp_q <= rem_fin;
        end
      end else if (compact_go) begin
        cmp_q <= cmp_q - RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      req_q  <= req_e'(req_type_i);
      port_q <= port_i;
      ip_q   <= ip_address_i;
      mac_q  <= hw_addr_i;
      now_q  <= now_time_i;
    end
    if (emit) begin
      okind_q <= e_kind;
      oport_q <= e_port;
      oip_q   <= e_ip;
      omac_q  <= e_mac;
      orem_q  <= e_rem;
      olast_q <= e_last;
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = okind_q;
  assign out_port_o      = oport_q;
  assign out_ip_o        = oip_q;
  assign found_hw_addr_o = omac_q;
  assign removed_count_o = orem_q;
  assign last_o          = olast_q;

endmodule

/* verif/tb_top.sv */
typedef struct {
  anc_pkg::req_e req;
  logic [2:0]    port;
  logic [31:0]   ip;
  logic [47:0]   mac;
  logic [31:0]   now;
} anc_req_t;

typedef struct {
  anc_pkg::kind_e kind;
  logic [2:0]     port;
  logic [31:0]    ip;
  logic [47:0]    mac;
  logic [5:0]     removed;
  logic           last;
} anc_res_t;

class neighbor_sb;
  logic        n_valid [32];
  logic [2:0]  n_port [32];
  logic [31:0] n_ip [32];
  logic [47:0] n_mac [32];
  logic [31:0] n_exp [32];
  logic [2:0]  n_retry [32];
  int          occ;
  logic [16:0] lifetime;
  logic [3:0]  num_ports;
  anc_res_t    pending[$];
  int          errors;

  function new();
    occ = 0;
    errors = 0;
    lifetime = anc_pkg::TIMEOUT_RESET;
    num_ports = anc_pkg::PORT_COUNT_RESET;
    foreach (n_valid[i]) n_valid[i] = 1'b0;
  endfunction

  function void set_cfg(anc_pkg::cfg_idx_e idx, logic [16:0] d);
    if (idx == anc_pkg::CFG_TIMEOUT) lifetime = d;
    else num_ports = d[3:0];
  endfunction

  function void push(anc_pkg::kind_e k, logic [2:0] p, logic [31:0] ip,
                     logic [47:0] mac, logic [5:0] rem);
    anc_res_t r;
    r.kind = k;
    r.port = p;
    r.ip = ip;
    r.mac = mac;
    r.removed = rem;
    r.last = 1'b0;
    pending.push_back(r);
  endfunction

  function void move_slot(int dst, int src);
    n_valid[dst] = n_valid[src];
    n_port[dst] = n_port[src];
    n_ip[dst] = n_ip[src];
    n_mac[dst] = n_mac[src];
    n_exp[dst] = n_exp[src];
    n_retry[dst] = n_retry[src];
  endfunction

  function int find(logic [2:0] p, logic [31:0] ip);
    for (int i = 0; i < occ; i++)
      if (n_valid[i] && n_port[i] == p && n_ip[i] == ip) return i;
    return -1;
  endfunction

  function void note_request(anc_req_t r);
    int before_n;
    int h;
    int w;
    int removed;
    logic [31:0] back;
    logic kill [32];
    before_n = pending.size();
    case (r.req)
      anc_pkg::REQ_LEARN: begin
        h = find(r.port, r.ip);
        if (h >= 0) begin
          for (int i = h; i > 0; i--) move_slot(i, i - 1);
          push(anc_pkg::KIND_UPDATED, 0, 0, 0, 0);
        end else if (occ >= 32) begin
          push(anc_pkg::KIND_FULL, 0, 0, 0, 0);
          h = -2;
        end else begin
          for (int i = occ; i > 0; i--) move_slot(i, i - 1);
          occ++;
          push(anc_pkg::KIND_CREATED, 0, 0, 0, 0);
        end
        if (h != -2) begin
          n_valid[0] = 1'b1;
          n_port[0] = r.port;
          n_ip[0] = r.ip;
          n_mac[0] = r.mac;
          n_exp[0] = r.now + 32'(lifetime);
          n_retry[0] = 3'd0;
        end
      end
      anc_pkg::REQ_LOOKUP: begin
        h = find(r.port, r.ip);
        if (4'(r.port) >= num_ports) push(anc_pkg::KIND_BADPORT, 0, 0, 0, 0);
        else if (h >= 0) push(anc_pkg::KIND_HIT, 0, 0, n_mac[h], 0);
        else push(anc_pkg::KIND_MISS, 0, 0, 0, 0);
      end
      anc_pkg::REQ_REFRESH: begin
        removed = 0;
        foreach (kill[i]) kill[i] = 1'b0;
        for (int s = occ - 1; s >= 0; s--) begin
          if (n_exp[s] > r.now) begin
            back = (32'(anc_pkg::RETRY_STEPS) - 32'(n_retry[s]))
                   * 32'(anc_pkg::RETRY_STEP_SEC);
            if (n_exp[s] - back > r.now) break;
            push(anc_pkg::KIND_PROBE, n_port[s], n_ip[s], 0, 0);
            n_retry[s] = n_retry[s] + 3'd1;
          end else begin
            kill[s] = 1'b1;
            removed++;
            if (removed == anc_pkg::REMOVE_LIMIT_DEF) break;
          end
        end
        w = 0;
        for (int i = 0; i < occ; i++)
          if (!kill[i]) begin
            if (w != i) move_slot(w, i);
            w++;
          end
        for (int i = w; i < 32; i++) n_valid[i] = 1'b0;
        occ = w;
        push(anc_pkg::KIND_DONE, 0, 0, 0, 6'(removed));
      end
      default: ;
    endcase
    if (pending.size() > before_n) pending[pending.size() - 1].last = 1'b1;
  endfunction

  function void check_result(anc_res_t a);
    anc_res_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result kind=%0d ip=%h", a.kind, a.ip);
      return;
    end
    e = pending.pop_front();
    if (a.kind != e.kind || a.port != e.port || a.ip != e.ip || a.mac != e.mac ||
        a.removed != e.removed || a.last != e.last) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch exp k=%0d p=%0d ip=%h mac=%h rm=%0d l=%0d",
                  " / act k=%0d p=%0d ip=%h mac=%h rm=%0d l=%0d"},
                 e.kind, e.port, e.ip, e.mac, e.removed, e.last,
                 a.kind, a.port, a.ip, a.mac, a.removed, a.last);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [2:0]  port = '0;
  logic [31:0] ip_address = '0;
  logic [47:0] hw_addr = '0;
  logic [31:0] now_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  out_port;
  logic [31:0] out_ip;
  logic [47:0] found_hw_addr;
  logic [5:0]  removed_count;
  logic        last;

  neighbor_sb  sb = new();
  int          cycles = 0;
  int          hold_left = 0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;
  logic [31:0] now_t;
  logic [31:0] ip_pool [40];

  arp_neighbor_cache_with_aging DUT (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .port_i(port), .ip_address_i(ip_address),
    .hw_addr_i(hw_addr), .now_time_i(now_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .out_port_o(out_port), .out_ip_o(out_ip),
    .found_hw_addr_o(found_hw_addr), .removed_count_o(removed_count),
    .last_o(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = rx_idle_en && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    anc_res_t a;
    if (rst_ni && out_valid && !out_stall) begin
      a.kind = anc_pkg::kind_e'(kind);
      a.port = out_port;
      a.ip = out_ip;
      a.mac = found_hw_addr;
      a.removed = removed_count;
      a.last = last;
      sb.check_result(a);
    end
  end

  task automatic send(anc_req_t q);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_type = q.req;
    port = q.port;
    ip_address = q.ip;
    hw_addr = q.mac;
    now_time = q.now;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(q);
  endtask

  task automatic send_f(anc_pkg::req_e t, logic [2:0] p, logic [31:0] ip,
                        logic [47:0] mac, logic [31:0] nw);
    anc_req_t q;
    q.req = t;
    q.port = p;
    q.ip = ip;
    q.mac = mac;
    q.now = nw;
    send(q);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(anc_pkg::cfg_idx_e idx, logic [16:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cfg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic rand_phase(int n);
    int sel;
    anc_req_t q;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      now_t = now_t + $urandom_range(0, 40);
      if ($urandom_range(99) < 5) now_t = $urandom;
      q.req = sel < 45 ? anc_pkg::REQ_LEARN : sel < 80 ? anc_pkg::REQ_LOOKUP :
              sel < 96 ? anc_pkg::REQ_REFRESH : anc_pkg::REQ_NONE;
      q.port = 3'($urandom_range(7));
      q.ip = ($urandom_range(99) < 15) ? $urandom : ip_pool[$urandom_range(39)];
      q.mac = {16'($urandom), 32'($urandom)};
      q.now = now_t;
      send(q);
    end
  endtask

  initial begin
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    now_t = 32'd1000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    send_f(anc_pkg::REQ_LEARN, 0, 32'h0, 48'h0, now_t);
    send_f(anc_pkg::REQ_LEARN, 7, 32'hffffffff, 48'hffffffffffff, now_t);
    send_f(anc_pkg::REQ_LEARN, 0, 32'h1, 48'h123456789abc, now_t);
    send_f(anc_pkg::REQ_LOOKUP, 0, 32'h0, 48'h0, now_t);
    send_f(anc_pkg::REQ_LOOKUP, 7, 32'hffffffff, 48'h0, now_t);
    send_f(anc_pkg::REQ_LOOKUP, 0, 32'h5, 48'h0, now_t);
    send_f(anc_pkg::REQ_LEARN, 0, 32'h0, 48'hfedcba987654, now_t + 5);
    send_f(anc_pkg::REQ_NONE, 3, 32'h77, 48'h1, now_t);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, now_t);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'd1900);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'd1901);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'd2205);
    drain();

    cfg_write(anc_pkg::CFG_TIMEOUT, 17'd86400);
    cfg_write(anc_pkg::CFG_PORT_COUNT, 17'd8);
    send_f(anc_pkg::REQ_LEARN, 7, 32'hc0a80001, 48'h0000000000ff, 32'hffffff00);
    send_f(anc_pkg::REQ_LOOKUP, 7, 32'hc0a80001, 48'h0, 32'h0);
    send_f(anc_pkg::REQ_LOOKUP, 3, 32'hc0a80001, 48'h0, 32'h0);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'hffffff10);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'h0);
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, 32'hffffffff);
    drain();

    cfg_write(anc_pkg::CFG_TIMEOUT, 17'd300);
    cfg_write(anc_pkg::CFG_PORT_COUNT, 17'd5);
    for (int i = 0; i < 34; i++)
      send_f(anc_pkg::REQ_LEARN, 3'($urandom_range(7)), ip_pool[i % 40] ^ 32'(i << 24),
             {16'($urandom), 32'($urandom)}, now_t);
    hold_left = 300;
    rand_phase(20);
    now_t = now_t + 250;
    send_f(anc_pkg::REQ_REFRESH, 0, 32'h0, 48'h0, now_t);
    rand_phase(25);
    drain();

    cfg_write(anc_pkg::CFG_TIMEOUT, 17'd1);
    cfg_write(anc_pkg::CFG_PORT_COUNT, 17'd1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rand_phase(40);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain();

    cfg_write(anc_pkg::CFG_TIMEOUT, 17'($urandom_range(200, 600)));
    cfg_write(anc_pkg::CFG_PORT_COUNT, 17'($urandom_range(2, 8)));
    rand_phase(15);
    drain();

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
